// File: src/sbst_pkg.sv
// sbst_pkg: shared types and constants for the sorted byte set table
// no dependencies; imported by sbst_mem, sbst_ctrl and the top level
package sbst_pkg;

    localparam int CAPACITY_DEFAULT = 32;
    localparam int VALUE_W = 7;
    localparam int OP_W = 2;
    localparam int FIELD_W = 6;

    // operation codes; the unused code behaves as a find
    localparam logic [OP_W-1:0] OP_FIND = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic               found;
        logic [FIELD_W-1:0] position;
        logic [FIELD_W-1:0] count;
        logic               rejected;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESOLVE,
        ST_SHIFT,
        ST_INSERT,
        ST_FINISH
    } ctrl_state_t;

endpackage

// File: src/sorted_byte_set_table_top.sv
// sorted byte set table: one request at a time, one result per request
// a find scans the entries in order; a remove then shifts the later entries down,
// an add shifts them up and then writes the new entry in an insert step
// the worst case is set by the scan and the shift over the store
// one request in flight at a time; a new request is taken while a result waits
// reset: entry count cleared at once; entry store is not cleared, no sweep needed
module sorted_byte_set_table_top #(
    parameter int CAPACITY = sbst_pkg::CAPACITY_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  sbst_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output sbst_pkg::rsp_t rsp
);
    import sbst_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic               mem_rd_en;
    logic [AW-1:0]      mem_rd_addr;
    logic [VALUE_W-1:0] mem_rd_data;
    logic               mem_wr_en;
    logic [AW-1:0]      mem_wr_addr;
    logic [VALUE_W-1:0] mem_wr_data;

    sbst_ctrl #(
        .CAPACITY(CAPACITY),
        .AW(AW),
        .CW(CW)
    ) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp),
        .mem_rd_en(mem_rd_en),
        .mem_rd_addr(mem_rd_addr),
        .mem_rd_data(mem_rd_data),
        .mem_wr_en(mem_wr_en),
        .mem_wr_addr(mem_wr_addr),
        .mem_wr_data(mem_wr_data)
    );

    sbst_mem #(
        .DEPTH(CAPACITY),
        .AW(AW)
    ) u_mem (
        .clk(clk),
        .rd_en(mem_rd_en),
        .rd_addr(mem_rd_addr),
        .rd_data(mem_rd_data),
        .wr_en(mem_wr_en),
        .wr_addr(mem_wr_addr),
        .wr_data(mem_wr_data)
    );

    // shift pipeline never reads the entry it is writing
    assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_rd_en && mem_wr_en && mem_rd_addr == mem_wr_addr))
        else $error("read and write collide on one entry");

    // store is left alone while waiting for a request
    assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> !mem_wr_en)
        else $error("store written while idle");

    // one item in flight: no request taken right after a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken while one is in flight");

    // a rejected add is always of a value not present
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.rejected && rsp.found))
        else $error("rejected result reports a present value");

endmodule

// File: src/sbst_mem.sv
// sbst_mem: entry store, one write port and one registered read port
// depends on sbst_pkg for the entry width
module sbst_mem #(
    parameter int DEPTH = sbst_pkg::CAPACITY_DEFAULT,
    parameter int AW = $clog2(DEPTH)
) (
    input  logic                         clk,
    input  logic                         rd_en,
    input  logic [AW-1:0]                rd_addr,
    output logic [sbst_pkg::VALUE_W-1:0] rd_data,
    input  logic                         wr_en,
    input  logic [AW-1:0]                wr_addr,
    input  logic [sbst_pkg::VALUE_W-1:0] wr_data
);
    import sbst_pkg::*;

    logic [VALUE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: src/sbst_ctrl.sv
// sbst_ctrl: sequencer that scans, shifts and inserts entries in the store
// depends on sbst_pkg; drives the ports of sbst_mem and holds the result register
module sbst_ctrl #(
    parameter int CAPACITY = sbst_pkg::CAPACITY_DEFAULT,
    parameter int AW = $clog2(CAPACITY),
    parameter int CW = $clog2(CAPACITY + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  sbst_pkg::req_t               req,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output sbst_pkg::rsp_t               rsp,
    output logic                         mem_rd_en,
    output logic [AW-1:0]                mem_rd_addr,
    input  logic [sbst_pkg::VALUE_W-1:0] mem_rd_data,
    output logic                         mem_wr_en,
    output logic [AW-1:0]                mem_wr_addr,
    output logic [sbst_pkg::VALUE_W-1:0] mem_wr_data
);
    import sbst_pkg::*;

    ctrl_state_t        state_reg, state_next;
    logic [OP_W-1:0]    op_reg, op_next;
    logic [VALUE_W-1:0] val_reg, val_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      pos_reg, pos_next;
    logic               found_reg, found_next;
    logic               rej_reg, rej_next;
    logic               up_reg, up_next;
    logic [AW-1:0]      src_reg, src_next;
    logic [CW-1:0]      remain_reg, remain_next;
    logic               wb_valid_reg, wb_valid_next;
    logic [AW-1:0]      wb_addr_reg, wb_addr_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_reg, rsp_next;

    logic [CW-1:0]         pos_inc;
    logic [CW+FIELD_W-1:0] pos_ext;
    logic [CW+FIELD_W-1:0] count_ext;

    assign pos_inc = pos_reg + CW'(1);
    assign pos_ext = {{FIELD_W{1'b0}}, pos_reg};
    assign count_ext = {{FIELD_W{1'b0}}, count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            wb_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            wb_valid_reg <= wb_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        val_reg <= val_next;
        pos_reg <= pos_next;
        found_reg <= found_next;
        rej_reg <= rej_next;
        up_reg <= up_next;
        src_reg <= src_next;
        remain_reg <= remain_next;
        wb_addr_reg <= wb_addr_next;
        rsp_reg <= rsp_next;
    end

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        val_next = val_reg;
        count_next = count_reg;
        pos_next = pos_reg;
        found_next = found_reg;
        rej_next = rej_reg;
        up_next = up_reg;
        src_next = src_reg;
        remain_next = remain_reg;
        wb_valid_next = 1'b0;
        wb_addr_next = wb_addr_reg;
        rsp_next = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        req_ready = 1'b0;
        mem_rd_en = 1'b0;
        mem_rd_addr = '0;
        mem_wr_en = 1'b0;
        mem_wr_addr = wb_addr_reg;
        mem_wr_data = mem_rd_data;

        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    // zero is never a member, so any operation on it is a find
                    op_next = (req.value == '0) ? OP_FIND : req.operation;
                    val_next = req.value;
                    pos_next = '0;
                    found_next = 1'b0;
                    rej_next = 1'b0;
                    if (req.value != '0 && count_reg != '0)
                    begin
                        mem_rd_en = 1'b1;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_RESOLVE;
                    end
                end
            end
            ST_SCAN:
            begin
                // read data holds entry pos_reg; next entry fetched ahead
                if (mem_rd_data < val_reg)
                begin
                    pos_next = pos_inc;
                    if (pos_inc < count_reg)
                    begin
                        mem_rd_en = 1'b1;
                        mem_rd_addr = pos_inc[AW-1:0];
                    end
                    else
                    begin
                        found_next = 1'b0;
                        state_next = ST_RESOLVE;
                    end
                end
                else
                begin
                    found_next = (mem_rd_data == val_reg);
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE:
            begin
                state_next = ST_FINISH;
                if (op_reg == OP_ADD && !found_reg)
                begin
                    if (count_reg == CW'(CAPACITY))
                    begin
                        rej_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + CW'(1);
                        up_next = 1'b1;
                        remain_next = count_reg - pos_reg;
                        src_next = count_reg[AW-1:0] - AW'(1);
                        state_next = ST_SHIFT;
                    end
                end
                else if (op_reg == OP_REMOVE && found_reg)
                begin
                    count_next = count_reg - CW'(1);
                    up_next = 1'b0;
                    remain_next = count_reg - pos_reg - CW'(1);
                    src_next = pos_inc[AW-1:0];
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                // read one entry per cycle, write it back one place over in the next cycle
                if (remain_reg != '0)
                begin
                    mem_rd_en = 1'b1;
                    mem_rd_addr = src_reg;
                    wb_valid_next = 1'b1;
                    wb_addr_next = up_reg ? src_reg + AW'(1) : src_reg - AW'(1);
                    src_next = up_reg ? src_reg - AW'(1) : src_reg + AW'(1);
                    remain_next = remain_reg - CW'(1);
                end
                if (wb_valid_reg)
                begin
                    mem_wr_en = 1'b1;
                end
                if (remain_reg == '0 && !wb_valid_reg)
                begin
                    state_next = up_reg ? ST_INSERT : ST_FINISH;
                end
            end
            ST_INSERT:
            begin
                mem_wr_en = 1'b1;
                mem_wr_addr = pos_reg[AW-1:0];
                mem_wr_data = val_reg;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next.found = found_reg;
                    rsp_next.position = pos_ext[FIELD_W-1:0];
                    rsp_next.count = count_ext[FIELD_W-1:0];
                    rsp_next.rejected = rej_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

endmodule
